FILE: design/edf_pkg.sv
// ----------------------------------------------------------------------------
// edf_pkg
// shared types for the earliest-deadline-first scheduler: controller commands
// and datapath status
// ----------------------------------------------------------------------------
package edf_pkg;

    localparam int TASK_COUNT_W = 5;
    localparam logic [TASK_COUNT_W-1:0] TASK_COUNT_RST = 5'd16;
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef struct packed {
        logic capture;
        logic scan_run;
        logic finish;
    } edf_cmd_t;

    typedef struct packed {
        logic func_tick;
        logic scan_done;
        logic out_free;
    } edf_status_t;

endpackage

FILE: design/edf_ctrl.sv
// ----------------------------------------------------------------------------
// edf_ctrl
// sequencer: accept one item, scan the task slots on a tick, then finish
// ----------------------------------------------------------------------------
module edf_ctrl
    import edf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  edf_status_t status,
    output edf_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd.capture  = 1'b0;
        cmd.scan_run = 1'b0;
        cmd.finish   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!status.func_tick || status.scan_done)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.scan_run = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: design/edf_dpath.sv
// ----------------------------------------------------------------------------
// edf_dpath
// task store, deadline scan, remaining-work update, lateness tracking and
// output register
// ----------------------------------------------------------------------------
module edf_dpath
    import edf_pkg::*;
#(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  edf_cmd_t                cmd,
    output edf_status_t             status,
    input  logic                    cfg_wr_en,
    input  logic [TASK_COUNT_W-1:0] cfg_wr_data,
    input  logic                    in_func,
    input  logic [3:0]              in_task_index,
    input  logic [15:0]             in_proc_time,
    input  logic [15:0]             in_release_time,
    input  logic [15:0]             in_deadline,
    input  logic                    m_tready,
    output logic                    m_tvalid,
    output logic                    ran_valid,
    output logic [3:0]              ran_index,
    output logic                    task_finished,
    output logic [15:0]             finish_time,
    output logic signed [17:0]      max_lateness,
    output logic                    lateness_valid
);

    localparam int IW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW  = IW + 1;
    localparam int LCW = (CW > TASK_COUNT_W) ? CW : TASK_COUNT_W;
    localparam int WW  = 3 * TIME_BITS;
    localparam int LW  = TIME_BITS + 2;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
    localparam logic [LCW-1:0] MAX_TASKS_C = LCW'(MAX_TASKS);

    // task store: {deadline, release, remaining}
    logic [WW-1:0]           mem [MAX_TASKS];
    logic [MAX_TASKS-1:0]    vld_reg;
    logic                    mem_we;
    logic [IW-1:0]           mem_wa;
    logic [WW-1:0]           mem_wd;
    logic [IW-1:0]           mem_ra;
    logic [WW-1:0]           rd_word_reg;
    logic                    rd_vld_reg;
    logic [IW-1:0]           rd_idx_reg;

    logic [TASK_COUNT_W-1:0] task_count_reg;
    logic                    func_reg;
    logic [3:0]              idx_reg;
    logic [TIME_BITS-1:0]    proc_reg;
    logic [TIME_BITS-1:0]    rel_reg;
    logic [TIME_BITS-1:0]    dl_reg;

    logic [CW-1:0]           cnt_reg;
    logic                    pend_reg;
    logic                    found_reg;
    logic [IW-1:0]           best_idx_reg;
    logic [TIME_BITS-1:0]    best_rem_reg;
    logic [TIME_BITS-1:0]    best_rel_reg;
    logic [TIME_BITS-1:0]    best_dl_reg;

    logic [TIME_BITS-1:0]    time_reg;
    logic signed [LW-1:0]    worst_reg;
    logic                    any_fin_reg;

    logic                    m_tvalid_reg;
    logic                    ran_valid_reg;
    logic [3:0]              ran_index_reg;
    logic                    finished_reg;
    logic [15:0]             finish_time_reg;
    logic signed [17:0]      max_late_reg;
    logic                    late_vld_reg;

    logic [LCW-1:0]          limit;
    logic                    issue;
    logic [TIME_BITS-1:0]    cand_rem;
    logic [TIME_BITS-1:0]    cand_rel;
    logic [TIME_BITS-1:0]    cand_dl;
    logic                    cand_ready;
    logic                    cand_take;
    logic                    load_ok;
    logic [TIME_BITS-1:0]    new_rem;
    logic                    done_now;
    logic signed [LW-1:0]    late;

    assign limit = (LCW'(task_count_reg) > MAX_TASKS_C) ? MAX_TASKS_C : LCW'(task_count_reg);
    assign issue = cmd.scan_run && (LCW'(cnt_reg) < limit);

    assign cand_rem   = rd_vld_reg ? rd_word_reg[TIME_BITS-1:0] : '0;
    assign cand_rel   = rd_word_reg[2*TIME_BITS-1:TIME_BITS];
    assign cand_dl    = rd_word_reg[WW-1:2*TIME_BITS];
    assign cand_ready = (cand_rel <= time_reg) && (cand_rem != '0);
    assign cand_take  = pend_reg && cand_ready && (!found_reg || (cand_dl < best_dl_reg));

    assign load_ok  = (32'(idx_reg) < MAX_TASKS);
    assign new_rem  = best_rem_reg - 1'b1;
    assign done_now = found_reg && (new_rem == '0);
    assign late     = LW'(time_reg) + LW'(1) - LW'(best_dl_reg);

    assign mem_ra = cnt_reg[IW-1:0];

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = IW'(idx_reg);
        mem_wd = {dl_reg, rel_reg, proc_reg};
        if (cmd.finish)
        begin
            if (func_reg == FUNC_LOAD)
            begin
                mem_we = load_ok;
            end
            else
            begin
                mem_we = found_reg;
                mem_wa = best_idx_reg;
                mem_wd = {best_dl_reg, best_rel_reg, new_rem};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_word_reg <= mem[mem_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= in_func;
            idx_reg  <= in_task_index;
            proc_reg <= TIME_BITS'(in_proc_time);
            rel_reg  <= TIME_BITS'(in_release_time);
            dl_reg   <= TIME_BITS'(in_deadline);
        end
        if (issue)
        begin
            rd_idx_reg <= mem_ra;
        end
        if (cand_take)
        begin
            best_idx_reg <= rd_idx_reg;
            best_rem_reg <= cand_rem;
            best_rel_reg <= cand_rel;
            best_dl_reg  <= cand_dl;
        end
        if (cmd.finish)
        begin
            ran_valid_reg   <= 1'b0;
            ran_index_reg   <= 4'd0;
            finished_reg    <= 1'b0;
            finish_time_reg <= 16'd0;
            max_late_reg    <= 18'(worst_reg);
            late_vld_reg    <= any_fin_reg;
            if (func_reg == FUNC_TICK && found_reg)
            begin
                ran_valid_reg <= 1'b1;
                ran_index_reg <= 4'(best_idx_reg);
                if (done_now)
                begin
                    finished_reg    <= 1'b1;
                    finish_time_reg <= 16'(time_reg);
                    late_vld_reg    <= 1'b1;
                    if (!any_fin_reg || (late > worst_reg))
                    begin
                        max_late_reg <= 18'(late);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg <= TASK_COUNT_RST;
            vld_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            cnt_reg        <= '0;
            pend_reg       <= 1'b0;
            found_reg      <= 1'b0;
            time_reg       <= '0;
            worst_reg      <= '0;
            any_fin_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                task_count_reg <= cfg_wr_data;
            end
            if (mem_we)
            begin
                vld_reg[mem_wa] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[mem_ra];
            if (cmd.capture)
            begin
                cnt_reg   <= '0;
                pend_reg  <= 1'b0;
                found_reg <= 1'b0;
            end
            else if (cmd.scan_run)
            begin
                pend_reg <= issue;
                if (issue)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (cand_take)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.finish && func_reg == FUNC_TICK)
            begin
                if (done_now)
                begin
                    any_fin_reg <= 1'b1;
                    if (!any_fin_reg || (late > worst_reg))
                    begin
                        worst_reg <= late;
                    end
                end
                if (time_reg != TIME_MAX)
                begin
                    time_reg <= time_reg + 1'b1;
                end
            end
            if (cmd.finish)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign status.func_tick = (func_reg == FUNC_TICK);
    assign status.scan_done = (LCW'(cnt_reg) == limit) && !pend_reg;
    assign status.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid       = m_tvalid_reg;
    assign ran_valid      = ran_valid_reg;
    assign ran_index      = ran_index_reg;
    assign task_finished  = finished_reg;
    assign finish_time    = finish_time_reg;
    assign max_lateness   = max_late_reg;
    assign lateness_valid = late_vld_reg;

endmodule

FILE: design/preemptive_edf_task_scheduler.sv
// ----------------------------------------------------------------------------
// preemptive_edf_task_scheduler
// preemptive earliest-deadline-first scheduler: load items fill task slots,
// tick items run the ready task with the earliest deadline for one time unit
// ----------------------------------------------------------------------------
// load item: the input is captured, the scan state is passed through, and the finish state
//   registers the result; the next input is taken once the sequencer is back in idle
// tick item: the scan reads one slot per cycle over the single read port of the task store,
//   min(task_count, MAX_TASKS) slots, before the finish state; with no slot enabled it costs as a load
// a result held back by m_tready stalls the input for as long as it waits
// reset: all slots empty, time and lateness zero, task_count 16, no clearing
//   pass needed (per-slot valid bits)
// ----------------------------------------------------------------------------
module preemptive_edf_task_scheduler
    import edf_pkg::*;
#(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,   // task_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,       // task_index, proc_time, release_time, deadline
    input  logic        s_tuser,       // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata        // ran_valid, ran_index, task_finished,
                                       // finish_time, max_lateness, lateness_valid
);

    edf_cmd_t           cmd;
    edf_status_t        status;
    logic               ran_valid;
    logic [3:0]         ran_index;
    logic               task_finished;
    logic [15:0]        finish_time;
    logic signed [17:0] max_lateness;
    logic               lateness_valid;

    edf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    edf_dpath #(
        .MAX_TASKS (MAX_TASKS),
        .TIME_BITS (TIME_BITS)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_func         (s_tuser),
        .in_task_index   (s_tdata[3:0]),
        .in_proc_time    (s_tdata[19:4]),
        .in_release_time (s_tdata[35:20]),
        .in_deadline     (s_tdata[51:36]),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .ran_valid       (ran_valid),
        .ran_index       (ran_index),
        .task_finished   (task_finished),
        .finish_time     (finish_time),
        .max_lateness    (max_lateness),
        .lateness_valid  (lateness_valid)
    );

    assign m_tdata = {7'd0, lateness_valid, max_lateness, finish_time,
                      task_finished, ran_index, ran_valid};

endmodule

FILE: tb/edf_result_checker.sv
// ----------------------------------------------------------------------------
// edf_result_checker
// watches the config port and both stream channels of the edf scheduler,
// keeps its own copy of the task slots, clock and lateness, and checks each
// result transfer field by field against the oldest predicted outcome
// ----------------------------------------------------------------------------
module edf_result_checker
    import edf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    output int          mismatches,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 16;
    localparam int REPORT_LIMIT = 10;

    // m_tdata[40:0] from the lowest bit up: ran_valid, ran_index,
    // task_finished, finish_time, max_lateness, lateness_valid
    typedef struct packed {
        logic               lateness_valid;
        logic signed [17:0] max_lateness;
        logic [15:0]        finish_time;
        logic               task_finished;
        logic [3:0]         ran_index;
        logic               ran_valid;
    } sched_result_t;

    logic [15:0]   work_left [SLOTS];
    logic [15:0]   release_at [SLOTS];
    logic [15:0]   due_at [SLOTS];
    logic [15:0]   now;
    int            worst_late;
    logic          any_done;
    logic [4:0]    task_count;
    sched_result_t outcome_q [$];
    int            errors;

    function automatic sched_result_t edf_step(input logic func, input logic [55:0] item);
        sched_result_t res;
        logic [3:0]    slot;
        int            limit;
        int            best;
        int            late;
        res = '0;
        slot = item[3:0];
        if (func == FUNC_LOAD)
        begin
            work_left[slot]  = item[19:4];
            release_at[slot] = item[35:20];
            due_at[slot]     = item[51:36];
        end
        else
        begin
            limit = (task_count > SLOTS) ? SLOTS : int'(task_count);
            best = -1;
            // earliest deadline among ready slots, lowest index on a tie
            for (int i = 0; i < limit; i++)
            begin
                if (release_at[i] <= now && work_left[i] != 16'd0)
                begin
                    if (best < 0)
                        best = i;
                    else if (due_at[i] < due_at[best])
                        best = i;
                end
            end
            if (best >= 0)
            begin
                res.ran_valid = 1'b1;
                res.ran_index = best[3:0];
                work_left[best] = work_left[best] - 16'd1;
                if (work_left[best] == 16'd0)
                begin
                    late = int'(now) + 1 - int'(due_at[best]);
                    res.task_finished = 1'b1;
                    res.finish_time = now;
                    if (!any_done || late > worst_late)
                        worst_late = late;
                    any_done = 1'b1;
                end
            end
            // clock saturates at all ones
            if (now != 16'hFFFF)
                now = now + 16'd1;
        end
        res.max_lateness = worst_late[17:0];
        res.lateness_valid = any_done;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        sched_result_t got;
        sched_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                work_left[i] = '0;
                release_at[i] = '0;
                due_at[i] = '0;
            end
            now = '0;
            worst_late = 0;
            any_done = 1'b0;
            task_count = TASK_COUNT_RST;
            outcome_q.delete();
            errors = 0;
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                task_count = cfg_wr_data;
            if (s_tvalid && s_tready)
                outcome_q.insert(outcome_q.size(), edf_step(s_tuser, s_tdata));
            if (m_tvalid && m_tready)
            begin
                got = sched_result_t'(m_tdata[40:0]);
                if (outcome_q.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("%0t: unexpected result transfer, data %h", $realtime, m_tdata);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (got !== want || m_tdata[47:41] !== 7'd0)
                    begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                        begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  expected ran=%0d idx=%0d fin=%0d ftime=%0d late=%0d lv=%0d",
                                     want.ran_valid, want.ran_index, want.task_finished,
                                     want.finish_time, want.max_lateness, want.lateness_valid);
                            $display("  actual   ran=%0d idx=%0d fin=%0d ftime=%0d late=%0d lv=%0d pad=%h",
                                     got.ran_valid, got.ran_index, got.task_finished,
                                     got.finish_time, got.max_lateness, got.lateness_valid,
                                     m_tdata[47:41]);
                        end
                    end
                end
            end
            mismatches <= errors;
            outstanding <= outcome_q.size();
        end
    end

endmodule

FILE: tb/tb_preemptive_edf_task_scheduler.sv
// ----------------------------------------------------------------------------
// tb_preemptive_edf_task_scheduler
// drives load and tick items into the edf scheduler: a directed pass over
// ties, preemption, late release, empty and masked slots and count extremes,
// random task batches under several task counts with random gaps on both
// sides and one long output stall, then tasks that finish past their
// deadlines; the checker module predicts and compares every result
// ----------------------------------------------------------------------------
module tb_preemptive_edf_task_scheduler
    import edf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 1250;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 25;
    localparam int WATCHDOG_LIMIT = 4000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [4:0]  cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;      // task_index, proc_time, release_time, deadline
    logic        s_tuser = 1'b0;    // func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;           // ran_valid, ran_index, task_finished,
                                    // finish_time, max_lateness, lateness_valid
    int          mismatches;
    int          outstanding;
    int          idle_cycles = 0;
    bit          steady = 1'b0;
    bit          hold_req = 1'b0;
    logic [15:0] stim_time = '0;

    always #1 clk = ~clk;

    preemptive_edf_task_scheduler dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    edf_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input logic func, input logic [55:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (func == FUNC_TICK && stim_time != 16'hFFFF)
            stim_time++;
    endtask

    task automatic load_task(input logic [3:0] slot, input logic [15:0] proc,
                             input logic [15:0] rel, input logic [15:0] due);
        send_item(FUNC_LOAD, {4'd0, due, rel, proc, slot});
    endtask

    task automatic send_tick();
        logic [55:0] junk;
        // payload is ignored on a tick, so fill it with noise
        junk = 56'({$urandom(), $urandom()});
        junk[55:52] = 4'd0;
        send_item(FUNC_TICK, junk);
    endtask

    task automatic random_load();
        logic [15:0] proc;
        logic [15:0] rel;
        logic [15:0] due;
        case ($urandom_range(0, 9))
            0:
            begin
                proc = 16'($urandom());
                rel  = 16'($urandom());
                due  = 16'($urandom());
            end
            1:
            begin
                proc = '0;
                rel  = stim_time;
                due  = stim_time + 16'($urandom_range(0, 10));
            end
            default:
            begin
                proc = 16'($urandom_range(1, 6));
                rel  = stim_time + 16'($urandom_range(0, 12));
                due  = stim_time + 16'($urandom_range(0, 50));
            end
        endcase
        load_task(4'($urandom_range(0, 15)), proc, rel, due);
    endtask

    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_task_count(input logic [4:0] count);
        wait_quiet();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [4:0] pick_count();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 5'd16;
            4, 5, 6:    return 5'($urandom_range(1, 15));
            7:          return 5'($urandom_range(17, 31));
            8:          return 5'd0;
            default:    return 5'($urandom_range(2, 8));
        endcase
    endfunction

    // receiver: random back-pressure plus one long hold-off on request
    initial
    begin
        int gap_left;
        gap_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (gap_left > 0 && !steady)
            begin
                m_tready <= 1'b0;
                gap_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                gap_left = 0;
                if ($urandom_range(0, 3) == 0)
                    gap_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int random_sent;
        int chunk;
        random_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // count above the slot total behaves as all slots
        write_task_count(5'd31);
        load_task(4'd2, 16'd1, 16'd0, 16'hFFFF);
        send_tick();
        send_tick();
        load_task(4'd0, 16'd2, 16'd0, 16'd20);
        load_task(4'd1, 16'd2, 16'd0, 16'd20);
        load_task(4'd3, 16'd0, 16'd0, 16'd0);
        load_task(4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        load_task(4'd4, 16'd1, 16'd5, 16'd1);
        repeat (6) send_tick();

        // slot beyond the count stays parked until the count covers it
        write_task_count(5'd4);
        load_task(4'd10, 16'd1, 16'd0, 16'd0);
        send_tick();
        write_task_count(5'd1);
        send_tick();
        write_task_count(5'd0);
        send_tick();
        write_task_count(5'd16);
        send_tick();

        while (random_sent < RANDOM_ITEMS)
        begin
            write_task_count(pick_count());
            steady = ($urandom_range(0, 4) == 0);
            chunk = $urandom_range(30, 90);
            for (int k = 0; k < chunk; k++)
            begin
                if (random_sent == 200)
                    hold_req = 1'b1;
                if ($urandom_range(0, 99) < 35)
                    random_load();
                else
                    send_tick();
                random_sent++;
            end
        end

        // tasks that finish well past their deadlines
        write_task_count(5'd16);
        steady = 1'b0;
        load_task(4'd0, 16'd2, 16'd0, 16'd0);
        load_task(4'd7, 16'd1, stim_time, 16'd0);
        repeat (4) send_tick();

        wait_quiet();
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
